// File: hdl/hsb_pkg.sv
// ============================================================================
// hsb_pkg
// Types and constants shared by the TCP handshake segment builder files.
// ============================================================================
`default_nettype none

package hsb_pkg;

	// Event kinds.
	localparam logic [1:0] KIND_OPEN    = 2'd0;
	localparam logic [1:0] KIND_SYN     = 2'd1;
	localparam logic [1:0] KIND_SYN_ACK = 2'd2;

	// Connection phases.
	localparam logic [1:0] PH_CLOSED   = 2'd0;
	localparam logic [1:0] PH_SYN_SENT = 2'd1;
	localparam logic [1:0] PH_SYN_RCVD = 2'd2;
	localparam logic [1:0] PH_ESTAB    = 2'd3;

	// TCP flag bits and fixed header fields.
	localparam logic [7:0]  FLAG_SYN        = 8'h02;
	localparam logic [7:0]  FLAG_ACK        = 8'h10;
	localparam logic [7:0]  HDR_OFFSET_BYTE = 8'h50;
	localparam logic [15:0] HDR_WINDOW      = 16'hFFFF;

	// Configuration register indexes.
	localparam int unsigned CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_OWN_PORT  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PEER_PORT = 2'd1;

	// One handshake event request.
	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] fresh_isn;
		logic [7:0]  seg_flags;
		logic [31:0] seg_seq;
		logic [31:0] seg_ack;
	} event_t;

	// One built segment header, or a rejection.
	typedef struct packed {
		logic        segment_valid;
		logic [15:0] out_src_port;
		logic [15:0] out_dst_port;
		logic [31:0] out_seq;
		logic [31:0] out_ack;
		logic [7:0]  out_offset_byte;
		logic [7:0]  out_flags;
		logic [15:0] out_window;
		logic [1:0]  conn_phase;
	} segment_t;

	// One configuration write request.
	typedef struct packed {
		logic [CFG_IDX_W-1:0] index;
		logic [15:0]          value;
	} cfg_t;

endpackage

`default_nettype wire

// File: hdl/hsb_channels.sv
// ============================================================================
// hsb_channels
// Valid/ready channel interfaces for events, segments and configuration.
// ============================================================================
`default_nettype none

interface hsb_event_if;
	logic              valid;
	logic              ready;
	hsb_pkg::event_t   data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface hsb_segment_if;
	logic              valid;
	logic              ready;
	hsb_pkg::segment_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface hsb_cfg_if;
	logic              valid;
	logic              ready;
	hsb_pkg::cfg_t     data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: hdl/tcp_handshake_segment_builder_unit.sv
// ============================================================================
// tcp_handshake_segment_builder_unit
// Tracks one TCP connection through the three-way handshake and builds the
// SYN, SYN-ACK or ACK header that each event calls for.
// ============================================================================
//
//   channel  direction  payload    purpose
//   -------  ---------  ---------  ----------------------------------------
//   evt      in         event_t    open, received SYN, received SYN-ACK
//   seg      out        segment_t  one header (or rejection) per event
//   cfg      in         cfg_t      own_port / peer_port writes
//
// Every event gives exactly one result. It is held in the input register,
// then the decision and header build go into the output register. One
// event per cycle is sustained while seg is ready; the phase and local
// sequence update as an event leaves the input register.
// arst_n clears the phase, the local sequence, both ports and the valids.
// A stall on seg holds the output register and stops the input register;
// cfg is always ready.
`default_nettype none

module tcp_handshake_segment_builder_unit (
	input  wire            clk,
	input  wire            arst_n,
	hsb_event_if.sink      evt,
	hsb_cfg_if.sink        cfg,
	hsb_segment_if.source  seg
);
	import hsb_pkg::*;

	logic        valid_s1;
	event_t      evt_s1;
	logic        valid_s2;
	segment_t    seg_s2;

	logic [1:0]  phase_q;
	logic [31:0] own_seq_q;
	logic [15:0] own_port_q;
	logic [15:0] peer_port_q;

	logic        s2_free;
	logic        advance;
	logic        evt_accept;

	logic [31:0] own_inc;
	logic [31:0] peer_inc;
	logic        ok;
	logic [1:0]  nxt_phase;
	logic [31:0] nxt_own_seq;
	logic [31:0] r_seq;
	logic [31:0] r_ack;
	logic [7:0]  r_flags;
	segment_t    res;

	// Handshake between the two register stages.
	assign s2_free    = !valid_s2 || seg.ready;
	assign advance    = valid_s1 && s2_free;
	assign evt.ready  = !valid_s1 || s2_free;
	assign evt_accept = evt.valid && evt.ready;
	assign cfg.ready  = 1'b1;

	assign seg.valid  = valid_s2;
	assign seg.data   = seg_s2;

	// Sequence increments wrap modulo 2^32.
	assign own_inc  = own_seq_q + 32'd1;
	assign peer_inc = evt_s1.seg_seq + 32'd1;

	// Check the event and choose the header contents and next state.
	always_comb begin
		ok          = 1'b0;
		nxt_phase   = phase_q;
		nxt_own_seq = own_seq_q;
		r_seq       = '0;
		r_ack       = '0;
		r_flags     = '0;
		case (evt_s1.kind)
			KIND_OPEN: begin
				ok          = 1'b1;
				nxt_phase   = PH_SYN_SENT;
				nxt_own_seq = evt_s1.fresh_isn;
				r_seq       = evt_s1.fresh_isn;
				r_flags     = FLAG_SYN;
			end
			KIND_SYN: begin
				if ((evt_s1.seg_flags & FLAG_SYN) != 8'd0) begin
					ok          = 1'b1;
					nxt_phase   = PH_SYN_RCVD;
					nxt_own_seq = evt_s1.fresh_isn;
					r_seq       = evt_s1.fresh_isn;
					r_ack       = peer_inc;
					r_flags     = FLAG_SYN | FLAG_ACK;
				end
			end
			KIND_SYN_ACK: begin
				if (((evt_s1.seg_flags & (FLAG_SYN | FLAG_ACK)) == (FLAG_SYN | FLAG_ACK))
						&& (evt_s1.seg_ack == own_inc)) begin
					ok        = 1'b1;
					nxt_phase = PH_ESTAB;
					r_seq     = own_inc;
					r_ack     = peer_inc;
					r_flags   = FLAG_ACK;
				end
			end
			default: begin
				ok = 1'b0;
			end
		endcase
	end

	// A rejected event yields an all-zero header and the unchanged phase.
	always_comb begin
		res.segment_valid   = ok;
		res.out_src_port    = ok ? own_port_q : 16'd0;
		res.out_dst_port    = ok ? peer_port_q : 16'd0;
		res.out_seq         = r_seq;
		res.out_ack         = r_ack;
		res.out_offset_byte = ok ? HDR_OFFSET_BYTE : 8'd0;
		res.out_flags       = r_flags;
		res.out_window      = ok ? HDR_WINDOW : 16'd0;
		res.conn_phase      = nxt_phase;
	end

	// Input register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (evt_accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// Input register payload.
	always_ff @(posedge clk) begin
		if (evt_accept) begin
			evt_s1 <= evt.data;
		end
	end

	// Output register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (seg.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (advance) begin
			seg_s2 <= res;
		end
	end

	// Connection state. The peer sequence is only ever echoed in the same
	// event that carries it, so it needs no register of its own.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_CLOSED;
			own_seq_q <= '0;
		end else if (advance) begin
			phase_q   <= nxt_phase;
			own_seq_q <= nxt_own_seq;
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_port_q  <= '0;
			peer_port_q <= '0;
		end else if (cfg.valid) begin
			case (cfg.data.index)
				REG_OWN_PORT: begin
					own_port_q <= cfg.data.value;
				end
				REG_PEER_PORT: begin
					peer_port_q <= cfg.data.value;
				end
				default: begin
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// File: hdl/hsb_checker.sv
// ============================================================================
// hsb_seg_props
// Port-level checks on the segment output of the handshake segment builder.
// ============================================================================
`default_nettype none

module hsb_seg_props (
	input wire                    clk,
	input wire                    arst_n,
	input wire                    seg_valid,
	input wire                    seg_ready,
	input wire hsb_pkg::segment_t seg_data
);
	import hsb_pkg::*;

	// A stalled result holds its contents.
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		seg_valid && !seg_ready |=> seg_valid && $stable(seg_data))
		else $error("segment changed while stalled");

	// A rejection carries an all-zero header.
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		seg_valid && !seg_data.segment_valid |->
		seg_data.out_flags == 8'd0 && seg_data.out_offset_byte == 8'd0 &&
		seg_data.out_window == 16'd0 && seg_data.out_seq == 32'd0 &&
		seg_data.out_ack == 32'd0)
		else $error("rejected event carries header fields");

	// A built header has the fixed offset and window.
	a_fixed_fields: assert property (@(posedge clk) disable iff (!arst_n)
		seg_valid && seg_data.segment_valid |->
		seg_data.out_offset_byte == HDR_OFFSET_BYTE &&
		seg_data.out_window == HDR_WINDOW)
		else $error("header offset or window wrong");

	// A SYN carries no acknowledgment and leaves the connection in syn sent.
	a_syn_phase: assert property (@(posedge clk) disable iff (!arst_n)
		seg_valid && seg_data.segment_valid && seg_data.out_flags == FLAG_SYN |->
		seg_data.out_ack == 32'd0 && seg_data.conn_phase == PH_SYN_SENT)
		else $error("SYN with wrong ack or phase");

	// A final ACK always goes with the established phase.
	a_ack_phase: assert property (@(posedge clk) disable iff (!arst_n)
		seg_valid && seg_data.segment_valid && seg_data.out_flags == FLAG_ACK |->
		seg_data.conn_phase == PH_ESTAB)
		else $error("ACK sent outside established phase");

endmodule

bind tcp_handshake_segment_builder_unit hsb_seg_props u_hsb_seg_props (
	.clk       (clk),
	.arst_n    (arst_n),
	.seg_valid (seg.valid),
	.seg_ready (seg.ready),
	.seg_data  (seg.data)
);

`default_nettype wire
